@@ rtl/nfwb_pkg.sv @@
// nfwb_pkg: shared types and constants of the nearest-four weighted binding block.
// No dependencies; used by every module under rtl/.

package nfwb_pkg;

  localparam int POS_W   = 32;   // Q16.16 coordinate
  localparam int ITEM_W  = 96;   // one stored particle (x, y, z)
  localparam int MAG_W   = 33;   // magnitude of one axis difference
  localparam int SQ_W    = 50;   // one squared term in Q34.16
  localparam int D2_W    = 48;   // saturated squared distance
  localparam int RAD_W   = 31;   // influence radius
  localparam int ID_W    = 11;
  localparam int WT_W    = 17;   // Q1.16 weight
  localparam int REC_W   = 61;   // reciprocal / quotient width
  localparam int DEN_W   = 63;   // divisor width (sum of four reciprocals)
  localparam int REM_W   = 64;   // divider remainder
  localparam int STEP_W  = 6;
  localparam int SLOTS   = 4;
  localparam int SQRT_W  = 64;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [WT_W-1:0]   ONE_Q16    = 17'd65536;
  localparam logic [ID_W-1:0]   ID_NONE    = '1;
  localparam logic [STEP_W-1:0] REC_STEPS  = 6'd60;
  localparam logic [STEP_W-1:0] FRAC_STEPS = 6'd16;
  localparam logic [17:0]       THREE_Q16  = 18'd196608;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
  } item_t;

  // one request to the shared long divider
  typedef struct packed {
    logic [REM_W-1:0]  rem0;
    logic [DEN_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef enum logic [3:0] {
    E_IDLE,
    E_SCAN,
    E_REC,
    E_REC_WAIT,
    E_SQRT,
    E_SQRT_WAIT,
    E_TDIV,
    E_TDIV_WAIT,
    E_SMOOTH1,
    E_SMOOTH2,
    E_NORM,
    E_NORM_WAIT,
    E_MUL,
    E_DONE
  } eng_state_t;

endpackage

@@ rtl/nfwb_queue.sv @@
// nfwb_queue: front end; accepts items, drops unused commands, two-entry queue.
// Depends on nfwb_pkg.

module nfwb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  nfwb_pkg::item_t in_item,
  output logic           q_valid,
  output nfwb_pkg::item_t q_item,
  input  logic           q_pop
);

  nfwb_pkg::item_t ents [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       known;

  assign known = (in_item.cmd == nfwb_pkg::CMD_CLEAR) ||
                 (in_item.cmd == nfwb_pkg::CMD_LOAD)  ||
                 (in_item.cmd == nfwb_pkg::CMD_QUERY);

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall && known;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = ents[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ents[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop && q_valid})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/nfwb_divider.sv @@
// nfwb_divider: restoring long divider, one quotient bit per cycle.
// Depends on nfwb_pkg. Quotient of rem0 followed by `steps` zero bits over den.

module nfwb_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  nfwb_pkg::div_req_t            req,
  output logic                          done,
  output logic [nfwb_pkg::REC_W-1:0]    quo
);

  logic                           busy;
  logic                           first;
  logic [nfwb_pkg::STEP_W-1:0]    cnt;
  logic [nfwb_pkg::REM_W-1:0]     rem;
  logic [nfwb_pkg::DEN_W-1:0]     den;
  logic [nfwb_pkg::REM_W-1:0]     shifted;
  logic [nfwb_pkg::REM_W-1:0]     den_ext;
  logic                           ge;

  assign den_ext = {1'b0, den};
  assign shifted = first ? rem : {rem[nfwb_pkg::REM_W-2:0], 1'b0};
  assign ge      = (shifted >= den_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      first <= 1'b1;
      rem   <= req.rem0;
      den   <= req.den;
      cnt   <= req.steps;
      quo   <= '0;
    end else if (busy) begin
      first <= 1'b0;
      rem   <= ge ? (shifted - den_ext) : shifted;
      quo   <= {quo[nfwb_pkg::REC_W-2:0], ge};
      cnt   <= cnt - 1'b1;
    end
  end

endmodule

@@ rtl/nfwb_isqrt.sv @@
// nfwb_isqrt: digit-by-digit integer square root of a 64-bit value, one digit a cycle.
// Depends on nfwb_pkg.

module nfwb_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nfwb_pkg::SQRT_W-1:0] val,
  output logic                        done,
  output logic [32:0]                 root
);

  logic                        busy;
  logic [4:0]                  cnt;
  logic [nfwb_pkg::SQRT_W-1:0] v;
  logic [nfwb_pkg::SQRT_W-1:0] res;
  logic [nfwb_pkg::SQRT_W-1:0] bitv;
  logic [nfwb_pkg::SQRT_W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[32:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= val;
      res  <= '0;
      bitv <= {2'b01, {(nfwb_pkg::SQRT_W-2){1'b0}}};
      cnt  <= 5'd31;
    end else if (busy) begin
      if (v >= trial) begin
        v   <= v - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

@@ rtl/nfwb_engine.sv @@
// nfwb_engine: back end; particle memory, distance scan, nearest-four list and
// weight math. Depends on nfwb_pkg, nfwb_divider, nfwb_isqrt.

module nfwb_engine #(
  parameter int MAX_PARTICLES = 1024,
  parameter int NEAREST_COUNT = 4
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        q_valid,
  input  nfwb_pkg::item_t                             q_item,
  output logic                                        q_pop,
  input  logic [nfwb_pkg::RAD_W-1:0]                  radius,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic [nfwb_pkg::SLOTS-1:0][nfwb_pkg::ID_W-1:0] ids,
  output logic [nfwb_pkg::SLOTS-1:0][nfwb_pkg::WT_W-1:0] wts
);

  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int NS = nfwb_pkg::SLOTS;

  nfwb_pkg::eng_state_t state, state_next;

  // particle memory
  logic [nfwb_pkg::ITEM_W-1:0] mem [MAX_PARTICLES];
  logic [nfwb_pkg::ITEM_W-1:0] rd_data;
  logic                        mem_we;
  logic                        rd_issue;

  logic [CW-1:0] count;
  logic [CW-1:0] scan_j;
  logic [nfwb_pkg::POS_W-1:0] vx, vy, vz;

  // scan pipeline
  logic          s_rd, s_mag, s_sq, s_sum;
  logic [CW-1:0] i_rd, i_mag, i_sq, i_sum;
  logic [nfwb_pkg::MAG_W-1:0] mx, my, mz;
  logic [nfwb_pkg::SQ_W-1:0]  sx, sy, sz;
  logic [nfwb_pkg::D2_W-1:0]  d2;
  logic [nfwb_pkg::MAG_W-1:0] dx, dy, dz;
  logic [2*nfwb_pkg::MAG_W-1:0] px2, py2, pz2;
  logic [nfwb_pkg::D2_W+3:0]  dsum;

  // nearest list
  logic [NS-1:0]                   kv;
  logic [NS-1:0][nfwb_pkg::D2_W-1:0] bd;
  logic [NS-1:0][CW-1:0]           bi;
  logic [NS-1:0]                   lt;
  logic [NS-1:0]                   slot_valid;
  logic [nfwb_pkg::D2_W-1:0]       r2;
  logic [2*nfwb_pkg::RAD_W-1:0]    rad_sq;

  // weight math
  logic [1:0]                          sk;
  logic [NS-1:0][nfwb_pkg::REC_W-1:0]  rec;
  logic [nfwb_pkg::DEN_W-1:0]          sum;
  logic [32:0]                         near_root;
  logic [nfwb_pkg::WT_W-1:0]           t;
  logic [2*nfwb_pkg::WT_W-1:0]         tt;
  logic [51:0]                         sm_prod;
  logic [19:0]                         smooth;
  logic [nfwb_pkg::WT_W-1:0]           falloff;
  logic [nfwb_pkg::WT_W-1:0]           norm;
  logic [2*nfwb_pkg::WT_W-1:0]         wprod;
  logic [NS-1:0][nfwb_pkg::WT_W-1:0]   wt;
  logic [nfwb_pkg::D2_W-1:0]           d_floor;

  logic                           div_start;
  nfwb_pkg::div_req_t             div_req;
  logic                           div_done;
  logic [nfwb_pkg::REC_W-1:0]     div_quo;
  logic                           sqrt_start;
  logic                           sqrt_done;
  logic [32:0]                    sqrt_root;

  logic scan_end;
  logic pop_load, pop_query, pop_clear;

  nfwb_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  nfwb_isqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .val   ({bd[0], 16'd0}),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign pop_clear = q_pop && (q_item.cmd == nfwb_pkg::CMD_CLEAR);
  assign pop_load  = q_pop && (q_item.cmd == nfwb_pkg::CMD_LOAD);
  assign pop_query = q_pop && (q_item.cmd == nfwb_pkg::CMD_QUERY);
  assign mem_we    = pop_load && (count < CW'(MAX_PARTICLES));
  assign rd_issue  = (state == nfwb_pkg::E_SCAN) && (scan_j < count);
  assign scan_end  = (scan_j == count) && !(s_rd || s_mag || s_sq || s_sum);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[AW-1:0]] <= {q_item.x, q_item.y, q_item.z};
    end
    rd_data <= mem[scan_j[AW-1:0]];
  end

  // distance datapath
  assign dx = {vx[31], vx} - {rd_data[95], rd_data[95:64]};
  assign dy = {vy[31], vy} - {rd_data[63], rd_data[63:32]};
  assign dz = {vz[31], vz} - {rd_data[31], rd_data[31:0]};
  assign px2 = mx * mx;
  assign py2 = my * my;
  assign pz2 = mz * mz;
  assign dsum = {2'b00, sx} + {2'b00, sy} + {2'b00, sz};

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      lt[k] = (k < NEAREST_COUNT) && (!kv[k] || (d2 < bd[k]));
    end
  end

  assign rad_sq = radius * radius;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      slot_valid[k] = kv[k] && (bd[k] < r2);
    end
  end

  assign d_floor = (bd[sk] == '0) ? nfwb_pkg::D2_W'(1) : bd[sk];
  assign sm_prod = tt * (nfwb_pkg::THREE_Q16 - {t, 1'b0});
  assign smooth  = (sm_prod[51:32] > 20'(nfwb_pkg::ONE_Q16)) ?
                   20'(nfwb_pkg::ONE_Q16) : sm_prod[51:32];
  assign wprod   = norm * falloff;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      nfwb_pkg::E_IDLE:
        if (pop_query) state_next = nfwb_pkg::E_SCAN;
      nfwb_pkg::E_SCAN:
        if (scan_end) state_next = nfwb_pkg::E_REC;
      nfwb_pkg::E_REC: begin
        if (slot_valid[sk]) begin
          state_next = nfwb_pkg::E_REC_WAIT;
        end else if (sk == 2'd3) begin
          state_next = slot_valid[0] ? nfwb_pkg::E_SQRT : nfwb_pkg::E_DONE;
        end
      end
      nfwb_pkg::E_REC_WAIT: begin
        if (div_done) begin
          if (sk == 2'd3) begin
            state_next = nfwb_pkg::E_SQRT;
          end else begin
            state_next = nfwb_pkg::E_REC;
          end
        end
      end
      nfwb_pkg::E_SQRT:      state_next = nfwb_pkg::E_SQRT_WAIT;
      nfwb_pkg::E_SQRT_WAIT: if (sqrt_done) state_next = nfwb_pkg::E_TDIV;
      nfwb_pkg::E_TDIV:      state_next = nfwb_pkg::E_TDIV_WAIT;
      nfwb_pkg::E_TDIV_WAIT: if (div_done) state_next = nfwb_pkg::E_SMOOTH1;
      nfwb_pkg::E_SMOOTH1:   state_next = nfwb_pkg::E_SMOOTH2;
      nfwb_pkg::E_SMOOTH2:   state_next = nfwb_pkg::E_NORM;
      nfwb_pkg::E_NORM: begin
        if (slot_valid[sk]) begin
          state_next = nfwb_pkg::E_NORM_WAIT;
        end else if (sk == 2'd3) begin
          state_next = nfwb_pkg::E_DONE;
        end
      end
      nfwb_pkg::E_NORM_WAIT: if (div_done) state_next = nfwb_pkg::E_MUL;
      nfwb_pkg::E_MUL:
        state_next = (sk == 2'd3) ? nfwb_pkg::E_DONE : nfwb_pkg::E_NORM;
      nfwb_pkg::E_DONE:
        if (!out_stall) state_next = nfwb_pkg::E_IDLE;
      default: state_next = nfwb_pkg::E_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop      = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    out_valid  = 1'b0;
    div_req    = '0;
    unique case (state)
      nfwb_pkg::E_IDLE: q_pop = q_valid;
      nfwb_pkg::E_REC: begin
        div_start     = slot_valid[sk];
        div_req.rem0  = nfwb_pkg::REM_W'(1);
        div_req.den   = nfwb_pkg::DEN_W'(d_floor);
        div_req.steps = nfwb_pkg::REC_STEPS;
      end
      nfwb_pkg::E_SQRT: sqrt_start = 1'b1;
      nfwb_pkg::E_TDIV: begin
        div_start     = 1'b1;
        div_req.rem0  = nfwb_pkg::REM_W'(near_root);
        div_req.den   = nfwb_pkg::DEN_W'(radius);
        div_req.steps = nfwb_pkg::FRAC_STEPS;
      end
      nfwb_pkg::E_NORM: begin
        div_start     = slot_valid[sk];
        div_req.rem0  = nfwb_pkg::REM_W'(rec[sk]);
        div_req.den   = sum;
        div_req.steps = nfwb_pkg::FRAC_STEPS;
      end
      nfwb_pkg::E_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      ids[k] = slot_valid[k] ? nfwb_pkg::ID_W'(bi[k]) : nfwb_pkg::ID_NONE;
      wts[k] = wt[k];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nfwb_pkg::E_IDLE;
      count <= '0;
      s_rd  <= 1'b0;
      s_mag <= 1'b0;
      s_sq  <= 1'b0;
      s_sum <= 1'b0;
    end else begin
      state <= state_next;
      if (pop_clear) begin
        count <= '0;
      end else if (mem_we) begin
        count <= count + 1'b1;
      end
      s_rd  <= rd_issue;
      s_mag <= s_rd;
      s_sq  <= s_mag;
      s_sum <= s_sq;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    r2 <= nfwb_pkg::D2_W'(rad_sq[2*nfwb_pkg::RAD_W-1:16]);

    i_rd  <= scan_j;
    i_mag <= i_rd;
    i_sq  <= i_mag;
    i_sum <= i_sq;
    mx <= dx[32] ? (~dx + 1'b1) : dx;
    my <= dy[32] ? (~dy + 1'b1) : dy;
    mz <= dz[32] ? (~dz + 1'b1) : dz;
    sx <= px2[2*nfwb_pkg::MAG_W-1:16];
    sy <= py2[2*nfwb_pkg::MAG_W-1:16];
    sz <= pz2[2*nfwb_pkg::MAG_W-1:16];
    d2 <= (|dsum[nfwb_pkg::D2_W+3:nfwb_pkg::D2_W]) ? '1 : dsum[nfwb_pkg::D2_W-1:0];

    if (rd_issue) begin
      scan_j <= scan_j + 1'b1;
    end

    if (s_sum) begin
      for (int k = 0; k < NS; k++) begin
        if (lt[k] && (k == 0 || !lt[(k == 0) ? 0 : k-1])) begin
          kv[k] <= 1'b1;
          bd[k] <= d2;
          bi[k] <= i_sum;
        end else if (k > 0 && lt[k]) begin
          kv[k] <= kv[(k == 0) ? 0 : k-1];
          bd[k] <= bd[(k == 0) ? 0 : k-1];
          bi[k] <= bi[(k == 0) ? 0 : k-1];
        end
      end
    end

    case (state)
      nfwb_pkg::E_IDLE: begin
        if (pop_query) begin
          vx     <= q_item.x;
          vy     <= q_item.y;
          vz     <= q_item.z;
          scan_j <= '0;
          kv     <= '0;
          wt     <= '0;
          sum    <= '0;
        end
      end
      nfwb_pkg::E_SCAN: sk <= 2'd0;
      nfwb_pkg::E_REC: begin
        if (!slot_valid[sk]) begin
          rec[sk] <= '0;
          sk      <= sk + 2'd1;
        end
      end
      nfwb_pkg::E_REC_WAIT: begin
        if (div_done) begin
          rec[sk] <= div_quo;
          sum     <= sum + nfwb_pkg::DEN_W'(div_quo);
          sk      <= sk + 2'd1;
        end
      end
      nfwb_pkg::E_SQRT_WAIT: if (sqrt_done) near_root <= sqrt_root;
      nfwb_pkg::E_TDIV_WAIT: begin
        if (div_done) begin
          t <= (div_quo > nfwb_pkg::REC_W'(nfwb_pkg::ONE_Q16)) ?
               nfwb_pkg::ONE_Q16 : div_quo[nfwb_pkg::WT_W-1:0];
        end
      end
      nfwb_pkg::E_SMOOTH1: tt <= t * t;
      nfwb_pkg::E_SMOOTH2: begin
        falloff <= nfwb_pkg::ONE_Q16 - smooth[nfwb_pkg::WT_W-1:0];
        sk      <= 2'd0;
      end
      nfwb_pkg::E_NORM: if (!slot_valid[sk]) sk <= sk + 2'd1;
      nfwb_pkg::E_NORM_WAIT: if (div_done) norm <= div_quo[nfwb_pkg::WT_W-1:0];
      nfwb_pkg::E_MUL: begin
        wt[sk] <= wprod[32:16];
        sk     <= sk + 2'd1;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/nearest_four_weighted_binding_top.sv @@
// Top level of the nearest-four weighted binding block.
// Depends on nfwb_pkg, nfwb_queue, nfwb_engine (and through it nfwb_divider, nfwb_isqrt).
//
// Usage:
//  - Input channel (in_valid / in_stall, fields cmd, pos_x, pos_y, pos_z): an item
//    is taken on a rising edge with in_valid high and in_stall low. cmd clear empties
//    the particle store, cmd load appends a particle (dropped when the store is full),
//    cmd query binds a vertex. Unused commands are taken and dropped.
//  - Output channel (out_valid / out_stall): one result item per query, four slots of
//    particle id (-1 when empty) and Q1.16 weight, nearest first.
//  - cfg_we / cfg_wdata writes influence_radius (unsigned Q15.16); write only when idle.
//  - A two-entry queue sits in front of the engine, so up to two items are still
//    taken while a result waits for the receiver.
//  - Clear and load are carried out by the engine as it takes them from the queue. A
//    query leaves the queue, scans every stored particle, then computes a reciprocal
//    for each of the V particles kept in range; with V > 0 it then takes the square
//    root, the falloff ratio, the smoothing and, per kept slot, a normalising division
//    and a multiply before the result is offered. The particle memory read port (one
//    particle a cycle) and the shared bit-serial divider bound the speed. Queries are worked one at a time.
//  - Reset (rst, synchronous) empties the store and sets the radius to 1.0; the
//    store needs no clearing pass.
//  - While out_stall is high the result holds steady; the queue fills and then
//    in_stall rises.

module nearest_four_weighted_binding_top #(
  parameter int MAX_PARTICLES = 1024,
  parameter int NEAREST_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [10:0] slot0_id,
  output logic signed [10:0] slot1_id,
  output logic signed [10:0] slot2_id,
  output logic signed [10:0] slot3_id,
  output logic [16:0]        slot0_weight,
  output logic [16:0]        slot1_weight,
  output logic [16:0]        slot2_weight,
  output logic [16:0]        slot3_weight
);

  nfwb_pkg::item_t in_item;
  nfwb_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;
  logic [nfwb_pkg::RAD_W-1:0] influence_radius;
  logic [nfwb_pkg::SLOTS-1:0][nfwb_pkg::ID_W-1:0] ids;
  logic [nfwb_pkg::SLOTS-1:0][nfwb_pkg::WT_W-1:0] wts;

  // radius register, reset to 1.0 in Q15.16
  always_ff @(posedge clk) begin
    if (rst) begin
      influence_radius <= 31'd65536;
    end else if (cfg_we) begin
      influence_radius <= cfg_wdata;
    end
  end

  assign in_item.cmd = cmd;
  assign in_item.x   = pos_x;
  assign in_item.y   = pos_y;
  assign in_item.z   = pos_z;

  // front: take and classify items
  nfwb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back: store, scan and weight math; holds the result until taken
  nfwb_engine #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .NEAREST_COUNT (NEAREST_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .radius    (influence_radius),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ids       (ids),
    .wts       (wts)
  );

  assign slot0_id     = ids[0];
  assign slot1_id     = ids[1];
  assign slot2_id     = ids[2];
  assign slot3_id     = ids[3];
  assign slot0_weight = wts[0];
  assign slot1_weight = wts[1];
  assign slot2_weight = wts[2];
  assign slot3_weight = wts[3];

endmodule

@@ rtl/nfwb_checker.sv @@
// nfwb_checker: port-level assertions on the binding result channel, bound to the top.
// Depends on nfwb_pkg and nearest_four_weighted_binding_top.

module nfwb_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [10:0] slot0_id,
  input logic [10:0] slot1_id,
  input logic [10:0] slot2_id,
  input logic [10:0] slot3_id,
  input logic [16:0] slot0_weight,
  input logic [16:0] slot1_weight,
  input logic [16:0] slot2_weight,
  input logic [16:0] slot3_weight
);

  logic [18:0] wsum;
  assign wsum = 19'(slot0_weight) + 19'(slot1_weight) + 19'(slot2_weight) +
                19'(slot3_weight);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((slot0_id != nfwb_pkg::ID_NONE || slot0_weight == '0) &&
                   (slot1_id != nfwb_pkg::ID_NONE || slot1_weight == '0) &&
                   (slot2_id != nfwb_pkg::ID_NONE || slot2_weight == '0) &&
                   (slot3_id != nfwb_pkg::ID_NONE || slot3_weight == '0)))
    else $error("empty slot carries a weight");

  a_packed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((slot1_id == nfwb_pkg::ID_NONE || slot0_id != nfwb_pkg::ID_NONE) &&
                   (slot2_id == nfwb_pkg::ID_NONE || slot1_id != nfwb_pkg::ID_NONE) &&
                   (slot3_id == nfwb_pkg::ID_NONE || slot2_id != nfwb_pkg::ID_NONE)))
    else $error("slots not filled nearest first");

  a_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (wsum <= 19'd65536))
    else $error("weights sum above one");

endmodule

bind nearest_four_weighted_binding_top nfwb_checker u_nfwb_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .slot0_id     (slot0_id),
  .slot1_id     (slot1_id),
  .slot2_id     (slot2_id),
  .slot3_id     (slot3_id),
  .slot0_weight (slot0_weight),
  .slot1_weight (slot1_weight),
  .slot2_weight (slot2_weight),
  .slot3_weight (slot3_weight)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking testbench for nearest_four_weighted_binding_top.
// Depends on nfwb_pkg and the RTL under rtl/; predicts each binding in-line.

module tb_top;

  localparam int STORE_DEPTH = 1024;
  localparam int IDLE_PCT    = 18;
  localparam int STALL_LIMIT = 60000;  // cycles with no item moving on either channel
  localparam int SETTLE      = 80;     // engine finishing a clear/load after the last result

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] x, y, z;
  } vec_item_t;

  typedef struct packed {
    logic [3:0][10:0] ids;
    logic [3:0][16:0] wts;
  } binding_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic [1:0] cmd = nfwb_pkg::CMD_CLEAR;
  logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
  logic cfg_we = 0;
  logic [30:0] cfg_wdata = 0;
  logic out_valid, out_stall = 0;
  logic signed [10:0] slot0_id, slot1_id, slot2_id, slot3_id;
  logic [16:0] slot0_weight, slot1_weight, slot2_weight, slot3_weight;

  nearest_four_weighted_binding_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_stall(out_stall),
    .slot0_id(slot0_id), .slot1_id(slot1_id), .slot2_id(slot2_id), .slot3_id(slot3_id),
    .slot0_weight(slot0_weight), .slot1_weight(slot1_weight),
    .slot2_weight(slot2_weight), .slot3_weight(slot3_weight)
  );

  initial forever #5 clk = ~clk;

  // predictor state: shadow particle store, count and radius
  logic [31:0] shadow_x [STORE_DEPTH];
  logic [31:0] shadow_y [STORE_DEPTH];
  logic [31:0] shadow_z [STORE_DEPTH];
  int unsigned shadow_count = 0;
  logic [30:0] radius_q16 = 31'd65536;

  vec_item_t pending_items[$];
  binding_t  binding_q[$];
  int  error_count = 0;
  int  items_queued = 0;
  bit  calm = 0;        // when set neither side idles
  int  quiet_cycles = 0;

  task automatic report(string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    error_count++;
  endtask

  // squared axis term, Q32.16
  function automatic longint unsigned axis_sq(logic [31:0] a, logic [31:0] b);
    longint d;
    longint unsigned m;
    d = longint'($signed(a)) - longint'($signed(b));
    m = (d < 0) ? longint'(-d) : d;
    return (m * m) >> 16;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else res >>= 1;
      bt >>= 2;
    end
    return res;
  endfunction

  // floor(num * 2^16 / den), num <= den
  function automatic longint unsigned ratio_q16(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = 0;
    if (den == 0) return 0;
    if (num >= den) begin q = 1; num -= den; end
    for (int i = 0; i < 16; i++) begin
      num <<= 1;
      q <<= 1;
      if (num >= den) begin num -= den; q |= 1; end
    end
    return q;
  endfunction

  // expected binding of one query vertex against the shadow store
  function automatic binding_t bind_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
    longint unsigned near_d[4], rec[4];
    int unsigned near_i[4];
    bit in_range[4];
    longint unsigned d2, r2, sum, root, t, sm, fo, dd;
    int unsigned kept, pos;
    binding_t b;
    kept = 0;
    sum = 0;
    for (int j = 0; j < shadow_count; j++) begin
      d2 = axis_sq(vx, shadow_x[j]) + axis_sq(vy, shadow_y[j]) + axis_sq(vz, shadow_z[j]);
      if (d2 > 64'hFFFF_FFFF_FFFF) d2 = 64'hFFFF_FFFF_FFFF;
      pos = 0;
      while (pos < kept && !(d2 < near_d[pos])) pos++;
      if (pos >= 4) continue;
      if (kept < 4) kept++;
      for (int k = kept - 1; k > pos; k--) begin
        near_d[k] = near_d[k-1];
        near_i[k] = near_i[k-1];
      end
      near_d[pos] = d2;
      near_i[pos] = j;
    end
    r2 = (longint'(radius_q16) * longint'(radius_q16)) >> 16;
    for (int k = 0; k < 4; k++) begin
      b.ids[k] = nfwb_pkg::ID_NONE;
      b.wts[k] = '0;
      in_range[k] = 0;
      rec[k] = 0;
    end
    for (int k = 0; k < kept; k++) begin
      if (near_d[k] >= r2) continue;
      in_range[k] = 1;
      b.ids[k] = near_i[k][10:0];
      dd = (near_d[k] < 1) ? 1 : near_d[k];
      rec[k] = (64'd1 << 60) / dd;
      sum += rec[k];
    end
    if (sum > 0 && in_range[0]) begin
      root = int_sqrt(near_d[0] << 16);
      t = (root << 16) / radius_q16;
      if (t > 65536) t = 65536;
      sm = (t * t * (3 * 65536 - 2 * t)) >> 32;
      if (sm > 65536) sm = 65536;
      fo = 65536 - sm;
      for (int k = 0; k < kept; k++)
        if (in_range[k]) b.wts[k] = 17'((ratio_q16(rec[k], sum) * fo) >> 16);
    end
    return b;
  endfunction

  // apply one accepted item to the shadow model
  task automatic predict_item(vec_item_t it);
    case (it.cmd)
      nfwb_pkg::CMD_CLEAR: shadow_count = 0;
      nfwb_pkg::CMD_LOAD: begin
        if (shadow_count < STORE_DEPTH) begin
          shadow_x[shadow_count] = it.x;
          shadow_y[shadow_count] = it.y;
          shadow_z[shadow_count] = it.z;
          shadow_count++;
        end
      end
      nfwb_pkg::CMD_QUERY: binding_q = {binding_q, bind_vertex(it.x, it.y, it.z)};
      default: ;  // unused command, dropped
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents items from pending_items; a stalled item holds steady.
  // ---------------------------------------------------------------------------
  vec_item_t on_bus;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_item(on_bus);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          on_bus = pending_items.pop_front();
          cmd   <= on_bus.cmd;
          pos_x <= on_bus.x;
          pos_y <= on_bus.y;
          pos_z <= on_bus.z;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, compares each result with the oldest binding.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    binding_t want, got;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.ids = {slot3_id, slot2_id, slot1_id, slot0_id};
        got.wts = {slot3_weight, slot2_weight, slot1_weight, slot0_weight};
        if (binding_q.size() == 0) begin
          report("result with no query pending");
        end else begin
          want = binding_q.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got.ids[k] !== want.ids[k])
              report($sformatf("slot%0d id got %0d want %0d", k,
                               $signed(got.ids[k]), $signed(want.ids[k])));
            if (got.wts[k] !== want.wts[k])
              report($sformatf("slot%0d weight got %0d want %0d", k,
                               got.wts[k], want.wts[k]));
          end
        end
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog: no item moving on either channel for too long ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("nearest_four_weighted_binding_top test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push(logic [1:0] c, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vec_item_t it;
    it.cmd = c; it.x = x; it.y = y; it.z = z;
    pending_items = {pending_items, it};
    items_queued++;
  endtask

  // block drained: nothing queued, on the bus or owed, then let the engine settle
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || binding_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_radius(logic [30:0] r);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    radius_q16 = r;
  endtask

  function automatic logic [31:0] jitter(logic [31:0] c, longint scale);
    longint off;
    off = longint'($urandom_range(0, 2 * scale)) - scale;
    return c + off[31:0];
  endfunction

  initial begin
    logic [30:0] r;
    logic [31:0] cx, cy, cz;
    longint scale;
    int n, q, phase;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store, exact hit, ties, more than four, out of range
    push(nfwb_pkg::CMD_QUERY, 0, 0, 0);
    push(nfwb_pkg::CMD_LOAD, 0, 0, 0);
    push(nfwb_pkg::CMD_LOAD, 32'h0000_4000, 0, 0);
    push(nfwb_pkg::CMD_LOAD, 0, 32'h0000_4000, 0);        // tie with the previous one
    push(nfwb_pkg::CMD_LOAD, 0, 0, 32'hFFFF_A000);
    push(nfwb_pkg::CMD_LOAD, 32'h0000_2000, 32'h0000_2000, 0);
    push(nfwb_pkg::CMD_LOAD, 32'h0002_0000, 0, 0);        // beyond radius 1.0
    push(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // unused command
    push(nfwb_pkg::CMD_QUERY, 0, 0, 0);
    push(nfwb_pkg::CMD_QUERY, 32'h0000_1000, 32'h0000_1000, 0);
    push(nfwb_pkg::CMD_QUERY, 32'h0003_0000, 0, 0);       // nothing in range
    push(nfwb_pkg::CMD_CLEAR, 0, 0, 0);
    push(nfwb_pkg::CMD_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push(nfwb_pkg::CMD_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push(nfwb_pkg::CMD_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);  // saturated
    set_radius(31'h7FFF_FFFF);
    push(nfwb_pkg::CMD_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push(nfwb_pkg::CMD_QUERY, 32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000);
    push(nfwb_pkg::CMD_QUERY, 0, 0, 0);
    set_radius(31'd1);                          // smallest radius, every slot empty
    push(nfwb_pkg::CMD_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

    // fill the store past capacity once; the extra appends are dropped
    set_radius(31'h0010_0000);
    calm = 1;
    push(nfwb_pkg::CMD_CLEAR, 0, 0, 0);
    for (int i = 0; i < STORE_DEPTH + 3; i++)
      push(nfwb_pkg::CMD_LOAD, jitter(0, 32'h0008_0000), jitter(0, 32'h0008_0000),
           jitter(0, 32'h0008_0000));
    push(nfwb_pkg::CMD_QUERY, jitter(0, 32'h0004_0000), 0, jitter(0, 32'h0004_0000));
    push(nfwb_pkg::CMD_QUERY, 0, 0, 0);
    drain();
    calm = 0;
    items_queued = 25;  // the bulk fill does not count toward the random part

    // random phases: clustered particles and queries around a center, some noise
    phase = 0;
    while (items_queued < 565) begin
      if (phase % 3 == 0) begin
        case ($urandom_range(4))
          0: r = 31'd1;
          1: r = 31'd65536;
          2: r = 31'h7FFF_FFFF;
          default: r = 31'($urandom_range(32'h0000_0400, 32'h0100_0000));
        endcase
        set_radius(r);
      end
      calm = (phase >= 6 && phase < 12);
      scale = (radius_q16 > 31'h1000_0000) ? 64'h1000_0000 : longint'(radius_q16);
      if ($urandom_range(3) == 0) scale = scale / 4 + 1;
      cx = $urandom; cy = $urandom; cz = $urandom;
      if ($urandom_range(3) != 0) begin
        cx = $signed(cx) >>> 10; cy = $signed(cy) >>> 10; cz = $signed(cz) >>> 10;
      end
      push(nfwb_pkg::CMD_CLEAR, $urandom, $urandom, $urandom);
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++)
        push(nfwb_pkg::CMD_LOAD, jitter(cx, scale), jitter(cy, scale), jitter(cz, scale));
      if ($urandom_range(3) == 0) push(nfwb_pkg::CMD_LOAD, cx, cy, cz);  // the center point itself
      q = $urandom_range(2, 6);
      for (int i = 0; i < q; i++) begin
        if ($urandom_range(9) == 0)
          push(2'($urandom_range(3)), $urandom, $urandom, $urandom);  // noise
        else
          push(nfwb_pkg::CMD_QUERY, jitter(cx, scale), jitter(cy, scale),
               jitter(cz, scale));
      end
      phase++;
    end

    drain();
    repeat (600) @(posedge clk);
    if (binding_q.size() != 0) report("bindings still owed at end");
    if (error_count == 0) begin
      $display("nearest_four_weighted_binding_top test passed");
    end else begin
      $display("nearest_four_weighted_binding_top test failed");
    end
    $finish;
  end

endmodule
